/* src/mqnc_pkg.sv */
`timescale 1ns / 1ps

package mqnc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int NUM_BINS    = 42;
  localparam int BIN_IDX_W   = $clog2(NUM_BINS);
  localparam int OUT_W       = 16;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIN_IDX_W-1:0]   bin_idx_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [1:0] FUNC_ATOM   = 2'd0;
  localparam logic [1:0] FUNC_BOND   = 2'd1;
  localparam logic [1:0] FUNC_RING   = 2'd2;
  localparam logic [1:0] FUNC_FINISH = 2'd3;

  localparam logic [1:0] BOND_OTHER = 2'd0;

  localparam logic [6:0] Z_DUMMY = 7'd0;
  localparam logic [6:0] Z_H     = 7'd1;
  localparam logic [6:0] Z_C     = 7'd6;
  localparam logic [6:0] Z_N     = 7'd7;
  localparam logic [6:0] Z_O     = 7'd8;
  localparam logic [6:0] Z_F     = 7'd9;
  localparam logic [6:0] Z_P     = 7'd15;
  localparam logic [6:0] Z_S     = 7'd16;
  localparam logic [6:0] Z_CL    = 7'd17;
  localparam logic [6:0] Z_BR    = 7'd35;
  localparam logic [6:0] Z_I     = 7'd53;

  localparam bin_idx_t BIN_C          = 6'd0;
  localparam bin_idx_t BIN_F          = 6'd1;
  localparam bin_idx_t BIN_CL         = 6'd2;
  localparam bin_idx_t BIN_BR         = 6'd3;
  localparam bin_idx_t BIN_I          = 6'd4;
  localparam bin_idx_t BIN_S          = 6'd5;
  localparam bin_idx_t BIN_P          = 6'd6;
  localparam bin_idx_t BIN_N_ACYC     = 6'd7;
  localparam bin_idx_t BIN_N_CYC      = 6'd8;
  localparam bin_idx_t BIN_O_ACYC     = 6'd9;
  localparam bin_idx_t BIN_O_CYC      = 6'd10;
  localparam bin_idx_t BIN_OTHER_HVY  = 6'd11;
  localparam bin_idx_t BIN_BOND_ACYC0 = 6'd11;
  localparam bin_idx_t BIN_BOND_CYC0  = 6'd14;
  localparam bin_idx_t BIN_CYC_SINGLE = 6'd15;
  localparam bin_idx_t BIN_CYC_DOUBLE = 6'd16;
  localparam bin_idx_t BIN_ROTATABLE  = 6'd18;
  localparam bin_idx_t BIN_ACC_SITES  = 6'd19;
  localparam bin_idx_t BIN_ACC_ATOMS  = 6'd20;
  localparam bin_idx_t BIN_DON_SITES  = 6'd21;
  localparam bin_idx_t BIN_DON_ATOMS  = 6'd22;
  localparam bin_idx_t BIN_NEG        = 6'd23;
  localparam bin_idx_t BIN_POS        = 6'd24;
  localparam bin_idx_t BIN_DEG1       = 6'd25;
  localparam bin_idx_t BIN_DEG_ACYC0  = 6'd24;
  localparam bin_idx_t BIN_DEG_CYC0   = 6'd27;
  localparam bin_idx_t BIN_RING0      = 6'd29;
  localparam bin_idx_t BIN_RING_BIG   = 6'd39;
  localparam bin_idx_t BIN_MULTI_ATOM = 6'd40;
  localparam bin_idx_t BIN_MULTI_BOND = 6'd41;
  localparam bin_idx_t BIN_LAST       = bin_idx_t'(NUM_BINS - 1);

  localparam logic [5:0] RING_MIN = 6'd3;
  localparam logic [5:0] RING_BIG = 6'd10;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic upd;
    logic fin;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

/* src/mqnc_ctrl.sv */
`timescale 1ns / 1ps

module mqnc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  output logic              out_valid,
  input  logic              out_ready,
  output mqnc_pkg::cmd_t    cmd,
  input  mqnc_pkg::sts_t    sts
);

  mqnc_pkg::state_t st_r;
  mqnc_pkg::state_t st_nxt;
  logic             in_acc;

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mqnc_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mqnc_pkg::ST_IDLE: begin
        if (in_acc && in_func == mqnc_pkg::FUNC_FINISH) begin
          st_nxt = mqnc_pkg::ST_EMIT;
        end
      end
      mqnc_pkg::ST_EMIT: begin
        if (out_ready && sts.last) begin
          st_nxt = mqnc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = mqnc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (st_r)
      mqnc_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.upd   = in_valid && in_func != mqnc_pkg::FUNC_FINISH;
        cmd.fin   = in_valid && in_func == mqnc_pkg::FUNC_FINISH;
      end
      mqnc_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.shift = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_fin_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> st_r == mqnc_pkg::ST_EMIT)
    else $error("finish item did not start emission");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && sts.last) |=> st_r == mqnc_pkg::ST_IDLE)
    else $error("emission did not end after the last bin");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.shift && (cmd.upd || cmd.fin)))
    else $error("update overlaps emission");

endmodule

/* src/mqnc_datapath.sv */
`timescale 1ns / 1ps

module mqnc_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mqnc_pkg::cmd_t             cmd,
  output mqnc_pkg::sts_t             sts,
  input  logic [1:0]                 in_func,
  input  logic [6:0]                 in_atomic_num,
  input  logic [3:0]                 in_hydrogens,
  input  logic [3:0]                 in_ring_membership,
  input  logic [3:0]                 in_degree,
  input  logic signed [3:0]          in_formal_charge,
  input  logic [1:0]                 in_bond_kind,
  input  logic                       in_aromatic,
  input  logic [5:0]                 in_ring_size,
  input  logic [15:0]                in_rotatable_bonds,
  output logic [mqnc_pkg::BIN_IDX_W-1:0] out_bin_index,
  output logic [mqnc_pkg::OUT_W-1:0] out_bin_count,
  output logic                       out_last
);

  mqnc_pkg::count_t   bin_r   [mqnc_pkg::NUM_BINS];
  mqnc_pkg::count_t   bin_nxt [mqnc_pkg::NUM_BINS];
  mqnc_pkg::count_t   amt     [mqnc_pkg::NUM_BINS];
  mqnc_pkg::count_t   arom_r;
  mqnc_pkg::count_t   arom_nxt;
  mqnc_pkg::bin_idx_t idx_r;
  mqnc_pkg::bin_idx_t idx_nxt;
  mqnc_pkg::count_t   half;
  mqnc_pkg::count_t   rot_sat;
  logic               in_rings;
  logic               multi;
  logic [mqnc_pkg::COUNT_WIDTH:0] sum [mqnc_pkg::NUM_BINS];
  logic [31:0]        wide_out;

  assign in_rings = in_ring_membership != 4'd0;
  assign multi    = in_ring_membership >= 4'd2;
  assign half     = arom_r >> 1;
  assign rot_sat  = (32'(in_rotatable_bonds) > 32'(mqnc_pkg::COUNT_MAX)) ?
                    mqnc_pkg::COUNT_MAX : mqnc_pkg::count_t'(in_rotatable_bonds);

  // per-bin increment for the item at the input
  always_comb begin
    for (int k = 0; k < mqnc_pkg::NUM_BINS; k++) begin
      amt[k] = '0;
    end
    if (cmd.upd) begin
      case (in_func)
        mqnc_pkg::FUNC_ATOM: begin
          case (in_atomic_num)
            mqnc_pkg::Z_DUMMY, mqnc_pkg::Z_H: ;
            mqnc_pkg::Z_C:  amt[mqnc_pkg::BIN_C]  = 'd1;
            mqnc_pkg::Z_F:  amt[mqnc_pkg::BIN_F]  = 'd1;
            mqnc_pkg::Z_CL: amt[mqnc_pkg::BIN_CL] = 'd1;
            mqnc_pkg::Z_BR: amt[mqnc_pkg::BIN_BR] = 'd1;
            mqnc_pkg::Z_I:  amt[mqnc_pkg::BIN_I]  = 'd1;
            mqnc_pkg::Z_S:  amt[mqnc_pkg::BIN_S]  = 'd1;
            mqnc_pkg::Z_P:  amt[mqnc_pkg::BIN_P]  = 'd1;
            mqnc_pkg::Z_N: begin
              amt[in_rings ? mqnc_pkg::BIN_N_CYC : mqnc_pkg::BIN_N_ACYC] = 'd1;
              if (in_degree != 4'd4) begin
                amt[mqnc_pkg::BIN_ACC_SITES] = 'd1;
                amt[mqnc_pkg::BIN_ACC_ATOMS] = 'd1;
              end
              if (in_hydrogens != 4'd0) begin
                amt[mqnc_pkg::BIN_DON_SITES] = mqnc_pkg::count_t'(in_hydrogens);
                amt[mqnc_pkg::BIN_DON_ATOMS] = 'd1;
              end
            end
            mqnc_pkg::Z_O: begin
              amt[in_rings ? mqnc_pkg::BIN_O_CYC : mqnc_pkg::BIN_O_ACYC] = 'd1;
              amt[mqnc_pkg::BIN_ACC_ATOMS] = 'd1;
              amt[mqnc_pkg::BIN_ACC_SITES] = (in_formal_charge == -4'sd1) ? 'd3 : 'd2;
              if (in_hydrogens != 4'd0) begin
                amt[mqnc_pkg::BIN_DON_SITES] = mqnc_pkg::count_t'(in_hydrogens);
                amt[mqnc_pkg::BIN_DON_ATOMS] = 'd1;
              end
            end
            default: amt[mqnc_pkg::BIN_OTHER_HVY] = 'd1;
          endcase
          if (in_formal_charge[3]) begin
            amt[mqnc_pkg::BIN_NEG] = 'd1;
          end else if (in_formal_charge != 4'sd0) begin
            amt[mqnc_pkg::BIN_POS] = 'd1;
          end
          if (in_atomic_num != mqnc_pkg::Z_H) begin
            if (in_degree == 4'd1) begin
              amt[mqnc_pkg::BIN_DEG1] = 'd1;
            end else if (in_degree >= 4'd2 && in_degree <= 4'd4) begin
              amt[(in_rings ? mqnc_pkg::BIN_DEG_CYC0 : mqnc_pkg::BIN_DEG_ACYC0)
                  + mqnc_pkg::bin_idx_t'(in_degree)] = 'd1;
            end
            if (multi) begin
              amt[mqnc_pkg::BIN_MULTI_ATOM] = 'd1;
            end
          end
        end
        mqnc_pkg::FUNC_BOND: begin
          if (!in_aromatic && in_bond_kind != mqnc_pkg::BOND_OTHER) begin
            amt[(in_rings ? mqnc_pkg::BIN_BOND_CYC0 : mqnc_pkg::BIN_BOND_ACYC0)
                + mqnc_pkg::bin_idx_t'(in_bond_kind)] = 'd1;
          end
          if (multi) begin
            amt[mqnc_pkg::BIN_MULTI_BOND] = 'd1;
          end
        end
        mqnc_pkg::FUNC_RING: begin
          if (in_ring_size >= mqnc_pkg::RING_MIN) begin
            if (in_ring_size < mqnc_pkg::RING_BIG) begin
              amt[mqnc_pkg::BIN_RING0 + mqnc_pkg::bin_idx_t'(in_ring_size)] = 'd1;
            end else begin
              amt[mqnc_pkg::BIN_RING_BIG] = 'd1;
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.fin) begin
      amt[mqnc_pkg::BIN_CYC_SINGLE] = half + mqnc_pkg::count_t'(arom_r[0]);
      amt[mqnc_pkg::BIN_CYC_DOUBLE] = half;
    end
  end

  // saturating add, rotatable overwrite, or shift toward bin 0
  always_comb begin
    for (int k = 0; k < mqnc_pkg::NUM_BINS; k++) begin
      sum[k] = {1'b0, bin_r[k]} + {1'b0, amt[k]};
      if (cmd.shift) begin
        bin_nxt[k] = (k == mqnc_pkg::NUM_BINS - 1) ? '0 :
                     bin_r[(k + 1) % mqnc_pkg::NUM_BINS];
      end else if (cmd.fin && k == int'(mqnc_pkg::BIN_ROTATABLE)) begin
        bin_nxt[k] = rot_sat;
      end else begin
        bin_nxt[k] = sum[k][mqnc_pkg::COUNT_WIDTH] ? mqnc_pkg::COUNT_MAX :
                     sum[k][mqnc_pkg::COUNT_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    arom_nxt = arom_r;
    idx_nxt  = idx_r;
    if (cmd.fin) begin
      arom_nxt = '0;
    end else if (cmd.upd && in_func == mqnc_pkg::FUNC_BOND && in_aromatic &&
                 arom_r != mqnc_pkg::COUNT_MAX) begin
      arom_nxt = arom_r + 1'b1;
    end
    if (cmd.shift) begin
      idx_nxt = sts.last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mqnc_pkg::NUM_BINS; k++) begin
        bin_r[k] <= '0;
      end
      arom_r <= '0;
      idx_r  <= '0;
    end else begin
      for (int k = 0; k < mqnc_pkg::NUM_BINS; k++) begin
        bin_r[k] <= bin_nxt[k];
      end
      arom_r <= arom_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign sts.last      = idx_r == mqnc_pkg::BIN_LAST;
  assign wide_out      = 32'(bin_r[0]);
  assign out_bin_count = (wide_out > 32'h0000_FFFF) ? {mqnc_pkg::OUT_W{1'b1}} :
                         wide_out[mqnc_pkg::OUT_W-1:0];
  assign out_bin_index = idx_r;
  assign out_last      = sts.last;

  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |=> bin_r[mqnc_pkg::NUM_BINS-1] == '0)
    else $error("tail bin not cleared on shift");

  a_shift_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |=> bin_r[0] == $past(bin_r[1]))
    else $error("counter row did not advance");

  a_arom_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> arom_r == '0 && idx_r == '0)
    else $error("finish left aromatic count or index dirty");

endmodule

/* src/molecular_quantum_number_counter_top.sv */
// Atom, bond and ring items: one per cycle when idle; counters update at the accept edge.
// Finish item: bin 0 is offered the cycle after accept, then one bin per cycle
// while out_ready is high; 42 results, input ready again after bin 41 is taken.
// A finish therefore blocks new input until all bins have been taken by the receiver.
// Reset (rst_n low, synchronous) clears all counters, the aromatic count and the index.
`timescale 1ns / 1ps

module molecular_quantum_number_counter_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_func,
  input  logic [6:0]             in_atomic_num,
  input  logic [3:0]             in_hydrogens,
  input  logic [3:0]             in_ring_membership,
  input  logic [3:0]             in_degree,
  input  logic signed [3:0]      in_formal_charge,
  input  logic [1:0]             in_bond_kind,
  input  logic                   in_aromatic,
  input  logic [5:0]             in_ring_size,
  input  logic [15:0]            in_rotatable_bonds,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             out_bin_index,
  output logic [15:0]            out_bin_count,
  output logic                   out_last
);

  mqnc_pkg::cmd_t cmd;
  mqnc_pkg::sts_t sts;

  mqnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mqnc_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_atomic_num      (in_atomic_num),
    .in_hydrogens       (in_hydrogens),
    .in_ring_membership (in_ring_membership),
    .in_degree          (in_degree),
    .in_formal_charge   (in_formal_charge),
    .in_bond_kind       (in_bond_kind),
    .in_aromatic        (in_aromatic),
    .in_ring_size       (in_ring_size),
    .in_rotatable_bonds (in_rotatable_bonds),
    .out_bin_index      (out_bin_index),
    .out_bin_count      (out_bin_count),
    .out_last           (out_last)
  );

endmodule

/* verif/mqnc_checker.sv */
`timescale 1ns / 1ps

module mqnc_checker
  import mqnc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [6:0]        in_atomic_num,
  input  logic [3:0]        in_hydrogens,
  input  logic [3:0]        in_ring_membership,
  input  logic [3:0]        in_degree,
  input  logic signed [3:0] in_formal_charge,
  input  logic [1:0]        in_bond_kind,
  input  logic              in_aromatic,
  input  logic [5:0]        in_ring_size,
  input  logic [15:0]       in_rotatable_bonds,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [5:0]        out_bin_index,
  input  logic [15:0]       out_bin_count,
  input  logic              out_last,
  output int                fail_count,
  output int                pending_bins,
  output int                checked_bins
);

  typedef struct {
    bin_idx_t         idx;
    logic [OUT_W-1:0] cnt;
    logic             last;
  } bin_result_t;

  bin_result_t emit_q[$];
  count_t      hist[NUM_BINS];
  count_t      arom_bonds;

  function automatic void add_to_bin(bin_idx_t b, longint unsigned amt);
    longint unsigned s;
    s = longint'(hist[b]) + amt;
    hist[b] = (s > COUNT_MAX) ? COUNT_MAX : count_t'(s);
  endfunction

  function automatic void tally_atom(logic [6:0] z, logic [3:0] nh, logic [3:0] rings,
                                     logic [3:0] deg, logic [3:0] q);
    case (z)
      Z_DUMMY, Z_H: ;
      Z_C:  add_to_bin(BIN_C, 1);
      Z_F:  add_to_bin(BIN_F, 1);
      Z_CL: add_to_bin(BIN_CL, 1);
      Z_BR: add_to_bin(BIN_BR, 1);
      Z_I:  add_to_bin(BIN_I, 1);
      Z_S:  add_to_bin(BIN_S, 1);
      Z_P:  add_to_bin(BIN_P, 1);
      Z_N: begin
        add_to_bin((rings != 0) ? BIN_N_CYC : BIN_N_ACYC, 1);
        if (deg != 4'd4) begin
          add_to_bin(BIN_ACC_SITES, 1);
          add_to_bin(BIN_ACC_ATOMS, 1);
        end
        if (nh != 0) begin
          add_to_bin(BIN_DON_SITES, nh);
          add_to_bin(BIN_DON_ATOMS, 1);
        end
      end
      Z_O: begin
        add_to_bin((rings != 0) ? BIN_O_CYC : BIN_O_ACYC, 1);
        add_to_bin(BIN_ACC_ATOMS, 1);
        add_to_bin(BIN_ACC_SITES, (q == 4'hF) ? 3 : 2);
        if (nh != 0) begin
          add_to_bin(BIN_DON_SITES, nh);
          add_to_bin(BIN_DON_ATOMS, 1);
        end
      end
      default: add_to_bin(BIN_OTHER_HVY, 1);
    endcase

    if (q[3]) add_to_bin(BIN_NEG, 1);
    else if (q != 0) add_to_bin(BIN_POS, 1);

    if (z != Z_H) begin
      if (deg == 4'd1) begin
        add_to_bin(BIN_DEG1, 1);
      end else if (deg >= 4'd2 && deg <= 4'd4) begin
        add_to_bin(bin_idx_t'(((rings != 0) ? BIN_DEG_CYC0 : BIN_DEG_ACYC0) + deg), 1);
      end
      if (rings >= 4'd2) add_to_bin(BIN_MULTI_ATOM, 1);
    end
  endfunction

  function automatic void tally_bond(logic [1:0] kind, logic arom, logic [3:0] rings);
    if (arom) begin
      if (arom_bonds != COUNT_MAX) arom_bonds = arom_bonds + 1'b1;
    end else if (kind != BOND_OTHER) begin
      add_to_bin(bin_idx_t'(((rings != 0) ? BIN_BOND_CYC0 : BIN_BOND_ACYC0) + kind), 1);
    end
    if (rings >= 4'd2) add_to_bin(BIN_MULTI_BOND, 1);
  endfunction

  function automatic void tally_ring(logic [5:0] size);
    if (size >= RING_MIN) begin
      add_to_bin((size < RING_BIG) ? bin_idx_t'(BIN_RING0 + size) : BIN_RING_BIG, 1);
    end
  endfunction

  function automatic void close_histogram(logic [15:0] rot);
    bin_result_t r;
    count_t      half;
    half = arom_bonds >> 1;
    add_to_bin(BIN_CYC_SINGLE, longint'(half) + arom_bonds[0]);
    add_to_bin(BIN_CYC_DOUBLE, half);
    hist[BIN_ROTATABLE] = (longint'(rot) > COUNT_MAX) ? COUNT_MAX : count_t'(rot);
    for (int k = 0; k < NUM_BINS; k++) begin
      r.idx  = bin_idx_t'(k);
      r.cnt  = (longint'(hist[k]) > 65535) ? 16'hFFFF : OUT_W'(hist[k]);
      r.last = (k == NUM_BINS - 1);
      emit_q.push_back(r);
      hist[k] = '0;
    end
    arom_bonds = '0;
  endfunction

  always @(posedge clk) begin
    bin_result_t exp_r;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      foreach (hist[k]) hist[k] = '0;
      arom_bonds   = '0;
      emit_q.delete();
      fail_count   <= 0;
      checked_bins <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (emit_q.size() == 0) begin
          $error("unexpected bin: index %0d count %0d last %0b",
                 out_bin_index, out_bin_count, out_last);
          errs++;
        end else begin
          exp_r = emit_q.pop_front();
          checked_bins <= checked_bins + 1;
          if (out_bin_index !== exp_r.idx) begin
            $error("bin_index: expected %0d, actual %0d", exp_r.idx, out_bin_index);
            errs++;
          end
          if (out_bin_count !== exp_r.cnt) begin
            $error("bin_count (bin %0d): expected %0d, actual %0d",
                   exp_r.idx, exp_r.cnt, out_bin_count);
            errs++;
          end
          if (out_last !== exp_r.last) begin
            $error("last (bin %0d): expected %0b, actual %0b",
                   exp_r.idx, exp_r.last, out_last);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_func)
          FUNC_ATOM:   tally_atom(in_atomic_num, in_hydrogens, in_ring_membership,
                                  in_degree, in_formal_charge);
          FUNC_BOND:   tally_bond(in_bond_kind, in_aromatic, in_ring_membership);
          FUNC_RING:   tally_ring(in_ring_size);
          FUNC_FINISH: close_histogram(in_rotatable_bonds);
          default: ;
        endcase
      end
      fail_count <= fail_count + errs;
    end
    pending_bins <= emit_q.size();
  end

endmodule

/* verif/tb_molecular_quantum_number_counter_top.sv */
`timescale 1ns / 1ps

module tb_molecular_quantum_number_counter_top;
  import mqnc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 220;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [1:0]        func;
    logic [6:0]        z;
    logic [3:0]        nh;
    logic [3:0]        rings;
    logic [3:0]        deg;
    logic signed [3:0] q;
    logic [1:0]        kind;
    logic              arom;
    logic [5:0]        rsize;
    logic [15:0]       rot;
  } record_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_func;
  logic [6:0]        in_atomic_num;
  logic [3:0]        in_hydrogens;
  logic [3:0]        in_ring_membership;
  logic [3:0]        in_degree;
  logic signed [3:0] in_formal_charge;
  logic [1:0]        in_bond_kind;
  logic              in_aromatic;
  logic [5:0]        in_ring_size;
  logic [15:0]       in_rotatable_bonds;
  logic              out_valid;
  logic              out_ready;
  logic [5:0]        out_bin_index;
  logic [15:0]       out_bin_count;
  logic              out_last;

  int fail_count;
  int pending_bins;
  int checked_bins;
  int idle_cycles;
  int atoms_sent;
  int bonds_sent;
  int rings_sent;
  int finishes_sent;
  bit no_gaps;

  molecular_quantum_number_counter_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_atomic_num      (in_atomic_num),
    .in_hydrogens       (in_hydrogens),
    .in_ring_membership (in_ring_membership),
    .in_degree          (in_degree),
    .in_formal_charge   (in_formal_charge),
    .in_bond_kind       (in_bond_kind),
    .in_aromatic        (in_aromatic),
    .in_ring_size       (in_ring_size),
    .in_rotatable_bonds (in_rotatable_bonds),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bin_index      (out_bin_index),
    .out_bin_count      (out_bin_count),
    .out_last           (out_last)
  );

  mqnc_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_atomic_num      (in_atomic_num),
    .in_hydrogens       (in_hydrogens),
    .in_ring_membership (in_ring_membership),
    .in_degree          (in_degree),
    .in_formal_charge   (in_formal_charge),
    .in_bond_kind       (in_bond_kind),
    .in_aromatic        (in_aromatic),
    .in_ring_size       (in_ring_size),
    .in_rotatable_bonds (in_rotatable_bonds),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bin_index      (out_bin_index),
    .out_bin_count      (out_bin_count),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending_bins       (pending_bins),
    .checked_bins       (checked_bins)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic record_t noise_record(logic [1:0] func);
    record_t r;
    r.func  = func;
    r.z     = 7'($urandom);
    r.nh    = 4'($urandom);
    r.rings = 4'($urandom);
    r.deg   = 4'($urandom);
    r.q     = 4'($urandom);
    r.kind  = 2'($urandom);
    r.arom  = 1'($urandom);
    r.rsize = 6'($urandom);
    r.rot   = 16'($urandom);
    return r;
  endfunction

  function automatic record_t atom_rec(logic [6:0] z, logic [3:0] nh, logic [3:0] rings,
                                       logic [3:0] deg, logic signed [3:0] q);
    record_t r;
    r = noise_record(FUNC_ATOM);
    r.z = z; r.nh = nh; r.rings = rings; r.deg = deg; r.q = q;
    return r;
  endfunction

  function automatic record_t bond_rec(logic [1:0] kind, logic arom, logic [3:0] rings);
    record_t r;
    r = noise_record(FUNC_BOND);
    r.kind = kind; r.arom = arom; r.rings = rings;
    return r;
  endfunction

  function automatic record_t ring_rec(logic [5:0] size);
    record_t r;
    r = noise_record(FUNC_RING);
    r.rsize = size;
    return r;
  endfunction

  function automatic record_t finish_rec(logic [15:0] rot);
    record_t r;
    r = noise_record(FUNC_FINISH);
    r.rot = rot;
    return r;
  endfunction

  function automatic record_t random_record();
    record_t     r;
    logic [6:0]  z;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return noise_record(2'($urandom));
    if (pick < 55) begin
      case ($urandom_range(0, 11))
        0:  z = Z_DUMMY;
        1:  z = Z_H;
        2:  z = Z_C;
        3:  z = Z_N;
        4:  z = Z_O;
        5:  z = Z_F;
        6:  z = Z_P;
        7:  z = Z_S;
        8:  z = Z_CL;
        9:  z = Z_BR;
        10: z = Z_I;
        default: z = 7'($urandom);
      endcase
      r = atom_rec(z, 4'($urandom_range(0, 4)), 4'($urandom_range(0, 3)),
                   4'($urandom_range(0, 6)), 4'($urandom_range(0, 2)) - 4'sd1);
      if ($urandom_range(0, 7) == 0) begin
        r.nh = 4'($urandom); r.deg = 4'($urandom); r.q = 4'($urandom);
        r.rings = 4'($urandom);
      end
      return r;
    end
    if (pick < 88) return bond_rec(2'($urandom), ($urandom_range(0, 3) == 0),
                                   4'($urandom_range(0, 3)));
    return ring_rec(($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(3, 12)));
  endfunction

  task automatic send(input record_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_func            <= r.func;
    in_atomic_num      <= r.z;
    in_hydrogens       <= r.nh;
    in_ring_membership <= r.rings;
    in_degree          <= r.deg;
    in_formal_charge   <= r.q;
    in_bond_kind       <= r.kind;
    in_aromatic        <= r.arom;
    in_ring_size       <= r.rsize;
    in_rotatable_bonds <= r.rot;
    do @(posedge clk); while (!in_ready);
    case (r.func)
      FUNC_ATOM:   atoms_sent++;
      FUNC_BOND:   bonds_sent++;
      FUNC_RING:   rings_sent++;
      FUNC_FINISH: finishes_sent++;
      default: ;
    endcase
  endtask

  // receiver: random stalls, quiet stretches, and two long hold-offs mid-finish
  initial begin
    int  stall;
    int  taken;
    bit  fast;
    taken = 0;
    fast  = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) fast = ($urandom_range(0, 3) == 0);
      if (taken == 150 || taken == 450) stall = LONG_HOLD;
      else stall = fast ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("molecular_quantum_number_counter_top test failed");
      $finish;
    end
  end

  initial begin
    int random_sent;
    int mol_len;
    idle_cycles   = 0;
    atoms_sent    = 0;
    bonds_sent    = 0;
    rings_sent    = 0;
    finishes_sent = 0;
    no_gaps       = 1'b0;
    random_sent   = 0;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_func            <= FUNC_ATOM;
    in_atomic_num      <= '0;
    in_hydrogens       <= '0;
    in_ring_membership <= '0;
    in_degree          <= '0;
    in_formal_charge   <= '0;
    in_bond_kind       <= BOND_OTHER;
    in_aromatic        <= 1'b0;
    in_ring_size       <= '0;
    in_rotatable_bonds <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send(atom_rec(Z_DUMMY, 4'd0, 4'd0, 4'd1, -4'sd8));
    send(atom_rec(Z_H, 4'd15, 4'd2, 4'd2, 4'sd7));
    send(atom_rec(Z_C, 4'd0, 4'd2, 4'd4, 4'sd0));
    send(atom_rec(Z_F, 4'd0, 4'd0, 4'd1, 4'sd0));
    send(atom_rec(Z_CL, 4'd0, 4'd0, 4'd0, 4'sd0));
    send(atom_rec(Z_BR, 4'd0, 4'd0, 4'd5, 4'sd1));
    send(atom_rec(Z_I, 4'd0, 4'd15, 4'd15, 4'sd0));
    send(atom_rec(Z_S, 4'd0, 4'd1, 4'd2, 4'sd0));
    send(atom_rec(Z_P, 4'd0, 4'd0, 4'd3, 4'sd0));
    send(atom_rec(Z_N, 4'd3, 4'd0, 4'd4, 4'sd0));
    send(atom_rec(Z_N, 4'd0, 4'd1, 4'd3, -4'sd1));
    send(atom_rec(Z_O, 4'd1, 4'd0, 4'd2, -4'sd1));
    send(atom_rec(Z_O, 4'd0, 4'd3, 4'd1, 4'sd0));
    send(atom_rec(7'd127, 4'd0, 4'd1, 4'd3, 4'sd0));
    send(bond_rec(2'd1, 1'b0, 4'd0));
    send(bond_rec(2'd2, 1'b0, 4'd1));
    send(bond_rec(2'd3, 1'b0, 4'd2));
    send(bond_rec(BOND_OTHER, 1'b0, 4'd0));
    send(bond_rec(2'd2, 1'b1, 4'd2));
    send(bond_rec(2'd1, 1'b1, 4'd1));
    send(bond_rec(2'd3, 1'b1, 4'd0));
    send(ring_rec(6'd2));
    send(ring_rec(6'd3));
    send(ring_rec(6'd9));
    send(ring_rec(6'd10));
    send(ring_rec(6'd63));
    send(finish_rec(16'hFFFF));
    send(finish_rec(16'h0000));

    while (random_sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      mol_len = $urandom_range(1, 24);
      repeat (mol_len) begin
        send(random_record());
        random_sent++;
      end
      if ($urandom_range(0, 9) != 0) begin
        send(finish_rec(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 20))));
        random_sent++;
      end
    end
    no_gaps = 1'b0;
    send(finish_rec(16'($urandom)));
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending_bins == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d atom, %0d bond, %0d ring records and %0d finishes; %0d bins compared.",
             atoms_sent, bonds_sent, rings_sent, finishes_sent, checked_bins);
    if (fail_count == 0) begin
      $display("molecular_quantum_number_counter_top test passed");
    end else begin
      $display("molecular_quantum_number_counter_top test failed");
    end
    $finish;
  end

endmodule
